@@ rtl/core/angular_poisson_coeff_scale_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the angular Poisson coefficient scaler
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ANGULAR_POISSON_COEFF_SCALE_MACROS_SVH
`define ANGULAR_POISSON_COEFF_SCALE_MACROS_SVH

// Same-cycle implication.
`define APCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apcs check failed");

// Next-cycle implication.
`define APCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apcs check failed");

`endif

@@ rtl/core/apcs_pkg.sv @@
// ----------------------------------------------------------------------------
// apcs_pkg
// Shared types, codes and helpers of the angular Poisson coefficient scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apcs_pkg;

  typedef struct packed {
    logic [7:0]  phi_index;
    logic [5:0]  theta_index;
    logic [63:0] coeff_in;
  } in_req_t;

  typedef struct packed {
    logic [63:0] coeff_out;
    logic [1:0]  action;
  } out_rsp_t;

  typedef enum logic [3:0] {
    BASIS_LEG = 4'd0,
    BASIS_P   = 4'd1,
    BASIS_PP  = 4'd2,
    BASIS_I   = 4'd3,
    BASIS_IP  = 4'd4,
    BASIS_PI  = 4'd5,
    BASIS_II  = 4'd6,
    BASIS_MP  = 4'd7,
    BASIS_MI  = 4'd8
  } basis_e;

  typedef enum logic [1:0] {
    ACT_PASS = 2'd0,
    ACT_ZERO = 2'd1,
    ACT_DIV  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_BASIS  = 2'd0,
    REG_LAMBDA = 2'd1,
    REG_THETA  = 2'd2,
    REG_PHI    = 2'd3
  } cfg_reg_e;

  // Sideband that rides along the shift adder.
  typedef struct packed {
    logic        solved;
    logic [63:0] coeff;
  } side_t;

  // 1.0e-14 as an IEEE double
  localparam logic [63:0] TINY_BITS   = 64'h3D06_849B_86A1_2B9B;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_ALL1    = 11'h7FF;

  // Leading zero count, 64 when the word is zero.
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] c;
    c = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) c = 7'(63 - i);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/apcs_fp_add.sv @@
// ----------------------------------------------------------------------------
// apcs_fp_add
// Four-stage double adder forming x = lambda - n for an integer n < 2^14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apcs_fp_add (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         lambda_i,
  input  logic [13:0]         prod_i,
  input  apcs_pkg::side_t     side_i,
  output logic                valid_o,
  output logic [63:0]         x_o,
  output apcs_pkg::side_t     side_o
);

  // ---- stage 1: unpack, order by magnitude
  logic [11:0] la_e, eb, e_big_d, e_small_d;
  logic [52:0] la_m, mb, m_big_d, m_small_d;
  logic [6:0]  lz_b;
  logic [5:0]  pb;
  logic        sb, a_ge, s_big_d, s_small_d, spec_d;
  logic [63:0] spec_val_d;

  always_comb begin
    la_e = (lambda_i[62:52] == 11'd0) ? 12'd1 : {1'b0, lambda_i[62:52]};
    la_m = {|lambda_i[62:52], lambda_i[51:0]};
    lz_b = apcs_pkg::lzc64({50'd0, prod_i});
    pb   = 6'(7'd63 - lz_b);
    if (prod_i == 14'd0) begin
      eb = 12'd1;
      mb = 53'd0;
      sb = 1'b0;
    end else begin
      eb = 12'd1023 + {6'd0, pb};
      mb = {39'd0, prod_i} << (6'd52 - pb);
      sb = 1'b1;
    end
    a_ge = {la_e, la_m} >= {eb, mb};
    if (a_ge) begin
      e_big_d = la_e; m_big_d = la_m; s_big_d = lambda_i[63];
      e_small_d = eb; m_small_d = mb; s_small_d = sb;
    end else begin
      e_big_d = eb; m_big_d = mb; s_big_d = sb;
      e_small_d = la_e; m_small_d = la_m; s_small_d = lambda_i[63];
    end
    spec_d     = (lambda_i[62:52] == apcs_pkg::EXP_ALL1);
    spec_val_d = (lambda_i[51:0] != 52'd0) ? (lambda_i | apcs_pkg::QUIET_BIT) : lambda_i;
  end

  logic            a1_vld_q, a1_spec_q, a1_sbig_q, a1_ssml_q;
  logic [63:0]     a1_spec_val_q;
  logic [11:0]     a1_ebig_q, a1_d_q;
  logic [52:0]     a1_mbig_q, a1_msml_q;
  apcs_pkg::side_t a1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a1_vld_q <= 1'b0;
    else if (en_i) a1_vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_spec_q     <= spec_d;
      a1_spec_val_q <= spec_val_d;
      a1_sbig_q     <= s_big_d;
      a1_ssml_q     <= s_small_d;
      a1_ebig_q     <= e_big_d;
      a1_d_q        <= e_big_d - e_small_d;
      a1_mbig_q     <= m_big_d;
      a1_msml_q     <= m_small_d;
      a1_side_q     <= side_i;
    end
  end

  // ---- stage 2: align and add
  logic [55:0] ext, al;
  logic [56:0] sum_d;

  always_comb begin
    ext = {a1_msml_q, 3'b000};
    if (a1_d_q >= 12'd56) begin
      al = {55'd0, |a1_msml_q};
    end else begin
      al    = ext >> a1_d_q;
      al[0] = al[0] | (|(ext & ~({56{1'b1}} << a1_d_q)));
    end
    if (a1_sbig_q ^ a1_ssml_q) sum_d = {1'b0, a1_mbig_q, 3'b000} - {1'b0, al};
    else                       sum_d = {1'b0, a1_mbig_q, 3'b000} + {1'b0, al};
  end

  logic            a2_vld_q, a2_spec_q, a2_sign_q;
  logic [63:0]     a2_spec_val_q;
  logic [11:0]     a2_e_q;
  logic [56:0]     a2_sum_q;
  apcs_pkg::side_t a2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a2_vld_q <= 1'b0;
    else if (en_i) a2_vld_q <= a1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_spec_q     <= a1_spec_q;
      a2_spec_val_q <= a1_spec_val_q;
      a2_sign_q     <= a1_sbig_q;
      a2_e_q        <= a1_ebig_q;
      a2_sum_q      <= sum_d;
      a2_side_q     <= a1_side_q;
    end
  end

  // ---- stage 3: leading zero count, limited by the exponent
  logic [55:0] r1_d;
  logic [11:0] e1_d;
  logic [6:0]  lz_r;
  logic [5:0]  sh_d;

  always_comb begin
    lz_r = 7'd0;
    if (a2_sum_q[56]) begin
      r1_d = {a2_sum_q[56:2], |a2_sum_q[1:0]};
      e1_d = a2_e_q + 12'd1;
      sh_d = 6'd0;
    end else begin
      r1_d = a2_sum_q[55:0];
      e1_d = a2_e_q;
      lz_r = apcs_pkg::lzc64({r1_d, 8'd0});
      if ({5'd0, lz_r} > a2_e_q - 12'd1) sh_d = 6'(a2_e_q - 12'd1);
      else                               sh_d = 6'(lz_r);
    end
  end

  logic            a3_vld_q, a3_spec_q, a3_sign_q, a3_ovf_q, a3_zero_q;
  logic [63:0]     a3_spec_val_q;
  logic [11:0]     a3_e_q;
  logic [5:0]      a3_sh_q;
  logic [55:0]     a3_r_q;
  apcs_pkg::side_t a3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a3_vld_q <= 1'b0;
    else if (en_i) a3_vld_q <= a2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_spec_q     <= a2_spec_q;
      a3_spec_val_q <= a2_spec_val_q;
      a3_sign_q     <= a2_sign_q;
      a3_ovf_q      <= (e1_d >= 12'd2047);
      a3_zero_q     <= (a2_sum_q == 57'd0);
      a3_e_q        <= e1_d;
      a3_sh_q       <= sh_d;
      a3_r_q        <= r1_d;
      a3_side_q     <= a2_side_q;
    end
  end

  // ---- stage 4: normalize, round to nearest even, pack
  logic [55:0] mn;
  logic [10:0] fld;
  logic        inc;
  logic [63:0] x_d;

  always_comb begin
    mn  = a3_r_q << a3_sh_q;
    fld = mn[55] ? 11'(a3_e_q - {6'd0, a3_sh_q}) : 11'd0;
    inc = mn[2] & (mn[3] | mn[1] | mn[0]);
    priority if (a3_spec_q) x_d = a3_spec_val_q;
    else if (a3_ovf_q)      x_d = {a3_sign_q, apcs_pkg::EXP_ALL1, 52'd0};
    else if (a3_zero_q)     x_d = 64'd0;
    else                    x_d = {a3_sign_q, fld, mn[54:3]} + {63'd0, inc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= a3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      side_o <= a3_side_q;
    end
  end

endmodule

@@ rtl/core/apcs_fp_div.sv @@
// ----------------------------------------------------------------------------
// apcs_fp_div
// Threshold test and pipelined double divide, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apcs_fp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  apcs_pkg::side_t     side_i,
  input  logic [63:0]         x_i,
  output logic                valid_o,
  output apcs_pkg::out_rsp_t  rsp_o
);

  localparam int QBITS = 54;

  typedef struct packed {
    logic        sign;
    logic        fin;
    logic [63:0] fin_val;
    logic [1:0]  act;
    logic [13:0] e;
    logic [54:0] r;
    logic [52:0] mb;
    logic [53:0] q;
  } dstage_t;

  // ---- P0: classify
  logic [63:0] a, b;
  logic        sgn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, tiny;
  logic        fin_d;
  logic [63:0] fin_val_d;
  logic [1:0]  act_d;
  logic [11:0] ea_d, eb_d;
  logic [52:0] ma_d, mb_d;

  always_comb begin
    a      = side_i.coeff;
    b      = x_i;
    sgn    = a[63] ^ b[63];
    a_nan  = (a[62:52] == apcs_pkg::EXP_ALL1) && (a[51:0] != 52'd0);
    b_nan  = (b[62:52] == apcs_pkg::EXP_ALL1) && (b[51:0] != 52'd0);
    a_inf  = (a[62:52] == apcs_pkg::EXP_ALL1) && (a[51:0] == 52'd0);
    b_inf  = (b[62:52] == apcs_pkg::EXP_ALL1) && (b[51:0] == 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    tiny   = b[62:0] < apcs_pkg::TINY_BITS[62:0];
    fin_d     = 1'b1;
    fin_val_d = 64'd0;
    act_d     = apcs_pkg::ACT_DIV;
    priority if (!side_i.solved) begin
      fin_val_d = a;
      act_d     = apcs_pkg::ACT_PASS;
    end else if (tiny) begin
      act_d = apcs_pkg::ACT_ZERO;
    end else if (a_nan) begin
      fin_val_d = a | apcs_pkg::QUIET_BIT;
    end else if (b_nan) begin
      fin_val_d = b | apcs_pkg::QUIET_BIT;
    end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
      fin_val_d = apcs_pkg::DEFAULT_NAN;
    end else if (a_inf || b_zero) begin
      fin_val_d = {sgn, apcs_pkg::EXP_ALL1, 52'd0};
    end else if (a_zero || b_inf) begin
      fin_val_d = {sgn, 63'd0};
    end else begin
      fin_d = 1'b0;
    end
    ea_d = (a[62:52] == 11'd0) ? 12'd1 : {1'b0, a[62:52]};
    eb_d = (b[62:52] == 11'd0) ? 12'd1 : {1'b0, b[62:52]};
    ma_d = {|a[62:52], a[51:0]};
    mb_d = {|b[62:52], b[51:0]};
  end

  logic        p0_vld_q, p0_sign_q, p0_fin_q;
  logic [63:0] p0_fin_val_q;
  logic [1:0]  p0_act_q;
  logic [11:0] p0_ea_q, p0_eb_q;
  logic [52:0] p0_ma_q, p0_mb_q;
  logic [5:0]  p0_lza_q, p0_lzb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p0_vld_q <= 1'b0;
    else if (en_i) p0_vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_sign_q    <= sgn;
      p0_fin_q     <= fin_d;
      p0_fin_val_q <= fin_val_d;
      p0_act_q     <= act_d;
      p0_ea_q      <= ea_d;
      p0_eb_q      <= eb_d;
      p0_ma_q      <= ma_d;
      p0_mb_q      <= mb_d;
      p0_lza_q     <= 6'(apcs_pkg::lzc64({11'd0, ma_d}) - 7'd11);
      p0_lzb_q     <= 6'(apcs_pkg::lzc64({11'd0, mb_d}) - 7'd11);
    end
  end

  // ---- P1: normalize operands, quotient exponent
  logic [52:0] na, nb;
  logic [13:0] e_raw;
  dstage_t     p1_d;

  always_comb begin
    na    = p0_ma_q << p0_lza_q;
    nb    = p0_mb_q << p0_lzb_q;
    e_raw = {2'd0, p0_ea_q} - {8'd0, p0_lza_q} - {2'd0, p0_eb_q} + {8'd0, p0_lzb_q}
            + 14'd1023;
    p1_d.sign    = p0_sign_q;
    p1_d.fin     = p0_fin_q;
    p1_d.fin_val = p0_fin_val_q;
    p1_d.act     = p0_act_q;
    p1_d.mb      = nb;
    p1_d.q       = '0;
    if (na < nb) begin
      p1_d.r = {1'b0, na, 1'b0};
      p1_d.e = e_raw - 14'd1;
    end else begin
      p1_d.r = {2'd0, na};
      p1_d.e = e_raw;
    end
  end

  // ---- restoring divide, one bit per stage
  dstage_t           dv_q   [QBITS+1];
  logic [QBITS:0]    dvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dvld_q[0] <= 1'b0;
    else if (en_i) dvld_q[0] <= p0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dv_q[0] <= p1_d;
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_iter
    logic        ge;
    logic [54:0] rn;
    dstage_t     nx;

    always_comb begin
      ge    = dv_q[i].r >= {2'd0, dv_q[i].mb};
      rn    = ge ? (dv_q[i].r - {2'd0, dv_q[i].mb}) : dv_q[i].r;
      nx    = dv_q[i];
      nx.r  = {rn[53:0], 1'b0};
      nx.q  = {dv_q[i].q[52:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvld_q[i+1] <= 1'b0;
      else if (en_i) dvld_q[i+1] <= dvld_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[i+1] <= nx;
    end
  end

  // ---- F1: overflow, subnormal shift
  dstage_t     fl;
  logic [13:0] sh14;
  logic [5:0]  shc;
  logic [53:0] m_d;
  logic [10:0] fld_d;
  logic        st_d, fin2_d;
  logic [63:0] fin_val2_d;

  always_comb begin
    fl         = dv_q[QBITS];
    sh14       = 14'd1 - fl.e;
    shc        = (sh14 > 14'd63) ? 6'd63 : 6'(sh14);
    st_d       = |fl.r;
    m_d        = fl.q;
    fld_d      = fl.e[10:0];
    fin2_d     = fl.fin;
    fin_val2_d = fl.fin_val;
    if (!fl.fin && ($signed(fl.e) >= 14'sd2047)) begin
      fin2_d     = 1'b1;
      fin_val2_d = {fl.sign, apcs_pkg::EXP_ALL1, 52'd0};
    end else if ($signed(fl.e) <= 14'sd0) begin
      fld_d = 11'd0;
      if (shc >= 6'(QBITS)) begin
        m_d  = '0;
        st_d = st_d | (|fl.q);
      end else begin
        m_d  = fl.q >> shc;
        st_d = st_d | (|(fl.q & ~({QBITS{1'b1}} << shc)));
      end
    end
  end

  logic        f1_vld_q, f1_sign_q, f1_fin_q, f1_st_q;
  logic [63:0] f1_fin_val_q;
  logic [1:0]  f1_act_q;
  logic [10:0] f1_fld_q;
  logic [53:0] f1_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1_vld_q <= 1'b0;
    else if (en_i) f1_vld_q <= dvld_q[QBITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_sign_q    <= fl.sign;
      f1_fin_q     <= fin2_d;
      f1_fin_val_q <= fin_val2_d;
      f1_act_q     <= fl.act;
      f1_st_q      <= st_d;
      f1_fld_q     <= fld_d;
      f1_m_q       <= m_d;
    end
  end

  // ---- F2: round to nearest even, pack
  logic                inc;
  logic [63:0]         packed_val;
  apcs_pkg::out_rsp_t  rsp_d;

  always_comb begin
    inc        = f1_m_q[0] & (f1_st_q | f1_m_q[1]);
    packed_val = {f1_sign_q, f1_fld_q, f1_m_q[52:1]} + {63'd0, inc};
    rsp_d.coeff_out = f1_fin_q ? f1_fin_val_q : packed_val;
    rsp_d.action    = f1_act_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= f1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rsp_o <= rsp_d;
  end

endmodule

@@ rtl/core/angular_poisson_coeff_scale.sv @@
// ----------------------------------------------------------------------------
// angular_poisson_coeff_scale: throughput one request per cycle while no result
// sits unclaimed; the 54 stage quotient array sets the depth.
// Async active-low reset empties the pipe and loads basis 0, lambda +0.0, counts 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module angular_poisson_coeff_scale #(
  parameter int MAX_THETA = 64,
  parameter int MAX_PHI   = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apcs_pkg::in_req_t   in_req_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apcs_pkg::out_rsp_t  out_rsp_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);

  // Pipeline map:
  //   T0  decode (k, j, basis) -> degree l, solved flag
  //   T1  l*(l+1)
  //   A1..A4  x = lambda - l(l+1), double add with RNE
  //   P0  |x| < 1e-14 test and special operands
  //   P1  operand normalize, quotient exponent
  //   54 quotient stages, F1 subnormal shift, F2 round/pack = output register
  // Whole pipe moves together; it stalls only while a result sits unclaimed.

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---- configuration registers
  logic [3:0]  basis_q;
  logic [63:0] lambda_q;
  logic [6:0]  theta_cnt_q;
  logic [7:0]  phi_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q     <= 4'd0;
      lambda_q    <= 64'd0;
      theta_cnt_q <= 7'd1;
      phi_cnt_q   <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (apcs_pkg::cfg_reg_e'(cfg_idx_i))
        apcs_pkg::REG_BASIS:  basis_q     <= cfg_wdata_i[3:0];
        apcs_pkg::REG_LAMBDA: lambda_q    <= cfg_wdata_i;
        apcs_pkg::REG_THETA:  theta_cnt_q <= cfg_wdata_i[6:0];
        apcs_pkg::REG_PHI:    phi_cnt_q   <= cfg_wdata_i[7:0];
      endcase
    end
  end

  // ---- T0: degree decode
  logic [7:0] k, lo, np;
  logic [5:0] j;
  logic [6:0] nt, mh, j2, deg_d;
  logic       odd_rows, known, j_ok, np_ok, solved_d;

  always_comb begin
    k  = in_req_i.phi_index;
    j  = in_req_i.theta_index;
    nt = (32'(theta_cnt_q) > MAX_THETA) ? 7'(MAX_THETA) : theta_cnt_q;
    np = (32'(phi_cnt_q) > MAX_PHI) ? 8'(MAX_PHI) : phi_cnt_q;
    mh = k[7:1];
    j2 = {j, 1'b0};
    odd_rows = (basis_q == apcs_pkg::BASIS_I)  || (basis_q == apcs_pkg::BASIS_IP) ||
               (basis_q == apcs_pkg::BASIS_PI) || (basis_q == apcs_pkg::BASIS_II) ||
               (basis_q == apcs_pkg::BASIS_MI);
    known = basis_q <= apcs_pkg::BASIS_MI;
    j_ok  = odd_rows ? (({1'b0, j} + 7'd1) < nt) : ({1'b0, j} < nt);
    np_ok = (np >= 8'd2) && (k <= np);
    lo    = 8'd0;
    deg_d = 7'd0;
    if (k == 8'd0) begin
      // m = 0 row: full j range
      unique case (basis_q)
        apcs_pkg::BASIS_LEG, apcs_pkg::BASIS_MP, apcs_pkg::BASIS_MI: deg_d = {1'b0, j};
        apcs_pkg::BASIS_P, apcs_pkg::BASIS_PP, apcs_pkg::BASIS_II:   deg_d = j2;
        default:                                                      deg_d = j2 + 7'd1;
      endcase
    end else begin
      unique case (basis_q)
        apcs_pkg::BASIS_LEG: begin
          lo = {2'd0, mh[6:1]}; deg_d = {1'b0, j};
        end
        apcs_pkg::BASIS_P: begin
          lo = {2'd0, mh[6:1]}; deg_d = j2 + {6'd0, mh[0]};
        end
        apcs_pkg::BASIS_PP: begin
          lo = {1'b0, mh}; deg_d = j2;
        end
        apcs_pkg::BASIS_I: begin
          lo = 8'(({1'b0, mh} + 8'd1) >> 1); deg_d = j2 + {6'd0, !mh[0]};
        end
        apcs_pkg::BASIS_IP: begin
          lo = {1'b0, mh}; deg_d = j2 + 7'd1;
        end
        apcs_pkg::BASIS_PI: begin
          lo = k[0] ? {1'b0, mh} : ({1'b0, mh} - 8'd1); deg_d = j2 + 7'd1;
        end
        apcs_pkg::BASIS_II: begin
          // k = 2 is its own row: every j, odd degree
          if (k == 8'd2) begin
            lo = 8'd0; deg_d = j2 + 7'd1;
          end else begin
            lo = {1'b0, mh} + {7'd0, k[0]}; deg_d = j2;
          end
        end
        apcs_pkg::BASIS_MP: begin
          lo = {k[7:1], 1'b0}; deg_d = {1'b0, j};
        end
        apcs_pkg::BASIS_MI: begin
          lo = (k - 8'd1) | 8'd1; deg_d = {1'b0, j};
        end
        default: begin
          lo = 8'd0; deg_d = 7'd0;
        end
      endcase
    end
    solved_d = known && j_ok && (k != 8'd1) &&
               ((k == 8'd0) || (np_ok && ({2'd0, j} >= lo)));
  end

  logic            t0_vld_q;
  logic [6:0]      t0_deg_q;
  apcs_pkg::side_t t0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t0_vld_q <= 1'b0;
    else if (en) t0_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_deg_q         <= deg_d;
      t0_side_q.solved <= solved_d;
      t0_side_q.coeff  <= in_req_i.coeff_in;
    end
  end

  // ---- T1: l(l+1), below 2^14 for l up to 127
  logic [14:0]     prod15;
  logic            t1_vld_q;
  logic [13:0]     t1_prod_q;
  apcs_pkg::side_t t1_side_q;

  assign prod15 = {8'd0, t0_deg_q} * ({8'd0, t0_deg_q} + 15'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_vld_q <= 1'b0;
    else if (en) t1_vld_q <= t0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_prod_q <= prod15[13:0];
      t1_side_q <= t0_side_q;
    end
  end

  // ---- x = lambda - l(l+1)
  logic            add_vld;
  logic [63:0]     add_x;
  apcs_pkg::side_t add_side;

  apcs_fp_add u_add (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (t1_vld_q),
    .lambda_i (lambda_q),
    .prod_i   (t1_prod_q),
    .side_i   (t1_side_q),
    .valid_o  (add_vld),
    .x_o      (add_x),
    .side_o   (add_side)
  );

  // ---- threshold, divide, output register
  apcs_fp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (add_vld),
    .side_i  (add_side),
    .x_i     (add_x),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

endmodule

@@ rtl/core/apcs_checker.sv @@
// ----------------------------------------------------------------------------
// apcs_checker
// Port-level checks on the coefficient scaler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "angular_poisson_coeff_scale_macros.svh"

module apcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input apcs_pkg::out_rsp_t  out_rsp_o
);

  logic zero_rsp;
  assign zero_rsp = out_valid_o && (out_rsp_o.action == apcs_pkg::ACT_ZERO);

  // stalled result holds
  `APCS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // pipe advances exactly when the output slot frees
  `APCS_ASSERT_IMP(a_ready_follows, 1'b1, in_ready_o == (!out_valid_o || out_ready_i))

  // zeroed results carry +0.0
  `APCS_ASSERT_IMP(a_zero_value, zero_rsp, out_rsp_o.coeff_out == 64'd0)

endmodule

bind angular_poisson_coeff_scale apcs_checker u_apcs_checker (.*);

@@ bench/apcs_checker.sv @@
// ----------------------------------------------------------------------------
// apcs_scoreboard
// Watches the request, result and configuration ports of the coefficient
// scaler, predicts each result from a local copy of the registers and
// compares it field by field with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apcs_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  apcs_pkg::in_req_t   in_req_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  apcs_pkg::out_rsp_t  out_rsp_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i,
  output int                  pending_o,
  output int                  fail_o
);

  localparam int MAX_THETA = 64;
  localparam int MAX_PHI   = 128;

  logic [3:0]         basis_q;
  logic [63:0]        lambda_q;
  logic [6:0]         theta_cnt_q;
  logic [7:0]         phi_cnt_q;
  apcs_pkg::out_rsp_t scaled_q[$];

  // Expected scaled coefficient for one request under the current registers.
  function automatic apcs_pkg::out_rsp_t scale_coeff(apcs_pkg::in_req_t r);
    int                 k, j, nt, np, jlim, m, lo, deg;
    bit                 odd_rows, solved;
    real                x;
    apcs_pkg::out_rsp_t o;
    k  = r.phi_index;
    j  = r.theta_index;
    nt = (theta_cnt_q > MAX_THETA) ? MAX_THETA : theta_cnt_q;
    np = (phi_cnt_q > MAX_PHI) ? MAX_PHI : phi_cnt_q;
    odd_rows = basis_q inside {apcs_pkg::BASIS_I, apcs_pkg::BASIS_IP, apcs_pkg::BASIS_PI,
                               apcs_pkg::BASIS_II, apcs_pkg::BASIS_MI};
    jlim = odd_rows ? nt - 1 : nt;
    solved = 1'b1;
    deg = 0;
    lo = 0;
    if (basis_q > apcs_pkg::BASIS_MI || j >= jlim || k == 1) solved = 1'b0;
    else if (k >= 2 && (np < 2 || k > np)) solved = 1'b0;
    else if (k == 0) begin
      case (basis_q)
        apcs_pkg::BASIS_LEG, apcs_pkg::BASIS_MP, apcs_pkg::BASIS_MI: deg = j;
        apcs_pkg::BASIS_P, apcs_pkg::BASIS_PP, apcs_pkg::BASIS_II:   deg = 2 * j;
        default:                                                      deg = 2 * j + 1;
      endcase
    end else begin
      case (basis_q)
        apcs_pkg::BASIS_LEG: begin m = k / 2; lo = m / 2; deg = j; end
        apcs_pkg::BASIS_P:   begin m = k / 2; lo = m / 2; deg = 2 * j + (m % 2); end
        apcs_pkg::BASIS_PP:  begin m = 2 * (k / 2); lo = m / 2; deg = 2 * j; end
        apcs_pkg::BASIS_I:   begin
          m = k / 2; lo = (m + 1) / 2; deg = 2 * j + ((m + 1) % 2);
        end
        apcs_pkg::BASIS_IP:  begin m = 2 * (k / 2); lo = m / 2; deg = 2 * j + 1; end
        apcs_pkg::BASIS_PI:  begin
          m = (k % 2 == 0) ? k - 1 : k;
          lo = (m - 1) / 2; deg = 2 * j + 1;
        end
        apcs_pkg::BASIS_II:  begin
          if (k == 2) begin
            lo = 0; deg = 2 * j + 1;
          end else begin
            m = (k % 2 == 0) ? k - 1 : k;
            lo = (m + 1) / 2; deg = 2 * j;
          end
        end
        apcs_pkg::BASIS_MP:  begin m = 2 * (k / 2); lo = m; deg = j; end
        default:             begin m = 2 * ((k - 1) / 2) + 1; lo = m; deg = j; end
      endcase
      if (j < lo) solved = 1'b0;
    end
    if (!solved) begin
      o.coeff_out = r.coeff_in;
      o.action    = apcs_pkg::ACT_PASS;
    end else begin
      x = real'(-(deg * (deg + 1))) + $bitstoreal(lambda_q);
      if (x < 1.0e-14 && x > -1.0e-14) begin
        o.coeff_out = '0;
        o.action    = apcs_pkg::ACT_ZERO;
      end else begin
        o.coeff_out = $realtobits($bitstoreal(r.coeff_in) / x);
        o.action    = apcs_pkg::ACT_DIV;
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    apcs_pkg::out_rsp_t want;
    int                 errs;
    errs = 0;
    if (!rst_ni) begin
      basis_q     <= apcs_pkg::BASIS_LEG;
      lambda_q    <= '0;
      theta_cnt_q <= 7'd1;
      phi_cnt_q   <= 8'd1;
      scaled_q.delete();
      pending_o   <= 0;
      fail_o      <= 0;
    end else begin
      // writes only happen while idle, so ordering against requests is moot
      if (cfg_we_i) begin
        case (apcs_pkg::cfg_reg_e'(cfg_idx_i))
          apcs_pkg::REG_BASIS:  basis_q     <= cfg_wdata_i[3:0];
          apcs_pkg::REG_LAMBDA: lambda_q    <= cfg_wdata_i;
          apcs_pkg::REG_THETA:  theta_cnt_q <= cfg_wdata_i[6:0];
          apcs_pkg::REG_PHI:    phi_cnt_q   <= cfg_wdata_i[7:0];
        endcase
      end
      if (in_valid_i && in_ready_i) scaled_q.push_back(scale_coeff(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (scaled_q.size() == 0) begin
          $error("unexpected result: coeff_out %h action %0d",
                 out_rsp_i.coeff_out, out_rsp_i.action);
          errs++;
        end else begin
          want = scaled_q.pop_front();
          if (out_rsp_i.coeff_out !== want.coeff_out) begin
            $error("coeff_out: expected %h, got %h", want.coeff_out, out_rsp_i.coeff_out);
            errs++;
          end
          if (out_rsp_i.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_rsp_i.action);
            errs++;
          end
        end
      end
      fail_o    <= fail_o + errs;
      pending_o <= scaled_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the coefficient scaler: a directed pass over the index and
// value corners, then random phases across bases, shifts and table sizes,
// with random stalls on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT  = 300000;
  localparam int DRAIN  = 80;     // a bit more than the pipe depth
  localparam int PHASES = 12;
  localparam int PER_PHASE = 130;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  apcs_pkg::in_req_t  in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  apcs_pkg::out_rsp_t out_rsp_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_wdata_i = '0;

  int pending, fails;
  int cyc = 0;
  int req_taken = 0;      // accepted requests, counted on the edge
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_kick = 0;      // bump to ask the result side for a long hold-off
  int cur_theta = 1, cur_phi = 1;

  always #6 clk_i = ~clk_i;

  angular_poisson_coeff_scale u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  apcs_scoreboard u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pending_o(pending), .fail_o(fails)
  );

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_taken <= req_taken + 1;
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request so the pipe
  // backs up and the request channel has to stall.
  always @(negedge clk_i) begin
    int hold_left, kick_seen;
    if (hold_kick != kick_seen) begin
      kick_seen = hold_kick;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic [7:0] k, input logic [5:0] j, input logic [63:0] c);
    int seen;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{phi_index: k, theta_index: j, coeff_in: c};
    seen = req_taken;
    do @(negedge clk_i); while (req_taken == seen);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_cfg(input apcs_pkg::cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == apcs_pkg::REG_THETA) cur_theta = val[6:0];
    if (idx == apcs_pkg::REG_PHI)   cur_phi   = val[7:0];
  endtask

  task automatic setup(input logic [3:0] basis, input logic [63:0] lam,
                       input logic [6:0] nt, input logic [7:0] np);
    write_cfg(apcs_pkg::REG_BASIS, 64'(basis));
    write_cfg(apcs_pkg::REG_LAMBDA, lam);
    write_cfg(apcs_pkg::REG_THETA, 64'(nt));
    write_cfg(apcs_pkg::REG_PHI, 64'(np));
  endtask

  function automatic logic [63:0] odd_double();
    case ($urandom_range(0, 7))
      0: return 64'h7FF0_0000_0000_0000;                        // +inf
      1: return 64'hFFF0_0000_0000_0000;                        // -inf
      2: return 64'h7FF8_0000_0000_0000 | {32'd0, $urandom};    // quiet NaN
      3: return 64'h7FF0_0000_0000_0001 | {32'd0, $urandom};    // signaling NaN
      4: return 64'h8000_0000_0000_0000;                        // -0
      5: return {32'h0000_0000, $urandom};                      // subnormal
      6: return 64'h7FEF_FFFF_FFFF_FFFF;                        // largest finite
      default: return 64'h0;
    endcase
  endfunction

  function automatic logic [63:0] pick_lambda();
    int  l;
    real v;
    l = $urandom_range(0, 130);
    v = real'(l * (l + 1));
    case ($urandom_range(0, 7))
      0, 1: return $realtobits(v);                      // hits a degree exactly
      2:    return $realtobits(v + 5.0e-15);
      3:    return $realtobits(v + 0.5);
      4:    return {$urandom, $urandom};
      5:    return odd_double();
      default: return $realtobits(v - 2.75);
    endcase
  endfunction

  function automatic logic [63:0] pick_coeff();
    if ($urandom_range(0, 99) < 12) return odd_double();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [3:0] basis;
    logic [6:0] nt;
    logic [7:0] np, k;
    logic [5:0] j;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers first (only k = 0, j = 0 solved), then corners.
    send_req(8'd0, 6'd0, 64'h3FF0_0000_0000_0000);
    send_req(8'd1, 6'd0, 64'hC000_0000_0000_0000);
    wait_idle();
    setup(apcs_pkg::BASIS_LEG, $realtobits(6.0), 7'd64, 8'd128);
    send_req(8'd0, 6'd2, 64'h4000_0000_0000_0000);    // x exactly zero
    send_req(8'd0, 6'd3, 64'h4000_0000_0000_0000);
    send_req(8'd1, 6'd5, 64'h1234_5678_9ABC_DEF0);    // k = 1 never solved
    send_req(8'd255, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF); // k above np
    send_req(8'd128, 6'd63, 64'h7FF0_0000_0000_0000);
    send_req(8'd128, 6'd31, 64'h3FF0_0000_0000_0000); // below lower bound
    send_req(8'd2, 6'd0, 64'h7FF8_0000_0000_0001);
    send_req(8'd3, 6'd0, 64'h0);
    send_req(8'd4, 6'd1, 64'h8000_0000_0000_0000);
    wait_idle();
    setup(apcs_pkg::BASIS_II, 64'h7FF8_0000_0000_0000, 7'd64, 8'd128); // NaN shift
    send_req(8'd2, 6'd0, 64'h4008_0000_0000_0000);    // k = 2 special row
    send_req(8'd0, 6'd63, 64'h4008_0000_0000_0000);   // last row, odd basis
    send_req(8'd0, 6'd62, 64'h4008_0000_0000_0000);
    wait_idle();
    setup(4'd15, $realtobits(2.0), 7'd127, 8'd255);   // unknown basis, saturating counts
    send_req(8'd0, 6'd0, 64'h4010_0000_0000_0000);
    send_req(8'd170, 6'd42, 64'hAAAA_5555_AAAA_5555);
    wait_idle();
    setup(apcs_pkg::BASIS_MI, 64'hFFF0_0000_0000_0000, 7'd0, 8'd0); // zero counts
    send_req(8'd0, 6'd0, 64'h4010_0000_0000_0000);
    send_req(8'd85, 6'd21, 64'h5555_AAAA_5555_AAAA);
    wait_idle();

    // Random phases over every basis, then random bases including unknown ones.
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        send_idle_pct = 11; recv_idle_pct = 49;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 49; recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      basis = (p <= apcs_pkg::BASIS_MI) ? 4'(p) : 4'($urandom_range(0, 15));
      case (p % 4)
        0: begin nt = 7'd64; np = 8'd128; end
        1: begin nt = 7'($urandom_range(1, 64)); np = 8'($urandom_range(2, 128)); end
        2: begin nt = 7'($urandom_range(2, 20)); np = 8'($urandom_range(2, 40)); end
        default: begin nt = 7'($urandom_range(0, 127)); np = 8'($urandom_range(0, 255)); end
      endcase
      setup(basis, pick_lambda(), nt, np);
      if (p == 1) hold_kick++;
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 75)
          k = 8'($urandom_range(0, (cur_phi + 1 > 255) ? 255 : cur_phi + 1));
        else
          k = 8'($urandom);
        if ($urandom_range(0, 99) < 75 && cur_theta > 0)
          j = 6'($urandom_range(0, (cur_theta > 64) ? 63 : cur_theta - 1));
        else
          j = 6'($urandom);
        send_req(k, j, pick_coeff());
      end
      wait_idle();
    end

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
